// File: design/brf_pkg.sv
package brf_pkg;

    // store size and index widths
    localparam int DEPTH = 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;

    // operation codes carried in the kind field
    typedef enum logic [2:0] {
        KIND_WRITE   = 3'd0,
        KIND_READ    = 3'd1,
        KIND_DISCARD = 3'd2,
        KIND_PEEK    = 3'd3,
        KIND_STATUS  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

// File: design/byte_ring_fifo_with_peek_core.sv
// channel   direction  handshake                  word
// -------   ---------  -------------------------  ---------------------------------------
// request   in         i_valid / o_ready          kind, write data, discard count, offset
// result    out        o_valid / i_ready          read data, ok, done, fill, spans
// config    in         i_cfg_valid / o_cfg_ready  capacity (ignored unless empty)
//
// each word passes through three steps: capture, execute, present result
// the single-port byte store is read or written in the execute cycle only
// the result is held until taken; no new request is taken meanwhile
// reset (synchronous, active low) empties the ring and sets capacity to the full store
// the store itself is not cleared: only held bytes are ever read back
module byte_ring_fifo_with_peek_core
    import brf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request channel
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_kind,
    input  logic [7:0]    i_write_data,
    input  logic [CW-1:0] i_discard_count,
    input  logic [7:0]    i_peek_offset,
    // result channel
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_read_data,
    output logic          o_ok,
    output logic [CW-1:0] o_done_count,
    output logic [CW-1:0] o_fill_level,
    output logic [CW-1:0] o_read_span,
    output logic [CW-1:0] o_write_span,
    // capacity register write
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [CW-1:0] i_cfg_capacity
);

    t_cmd cmd;

    // capacity writes are always taken; the datapath drops them when not empty
    assign o_cfg_ready = 1'b1;

    // sequencing of capture, execute and result hand-off
    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    // ring pointers, byte store and status arithmetic
    brf_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_capacity  (i_cfg_capacity),
        .i_kind          (i_kind),
        .i_write_data    (i_write_data),
        .i_discard_count (i_discard_count),
        .i_peek_offset   (i_peek_offset[AW-1:0]),
        .o_read_data     (o_read_data),
        .o_ok            (o_ok),
        .o_done_count    (o_done_count),
        .o_fill_level    (o_fill_level),
        .o_read_span     (o_read_span),
        .o_write_span    (o_write_span)
    );

endmodule

// File: design/brf_ctrl.sv
module brf_ctrl
    import brf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.capture   = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.execute   = 1'b1;
            end
            ST_RESP: begin
                o_out_valid     = 1'b1;
            end
            default: begin
                o_in_ready      = 1'b0;
            end
        endcase
    end

endmodule

// File: design/brf_datapath.sv
module brf_datapath
    import brf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_capacity,
    input  logic [2:0]    i_kind,
    input  logic [7:0]    i_write_data,
    input  logic [CW-1:0] i_discard_count,
    input  logic [AW-1:0] i_peek_offset,
    output logic [7:0]    o_read_data,
    output logic          o_ok,
    output logic [CW-1:0] o_done_count,
    output logic [CW-1:0] o_fill_level,
    output logic [CW-1:0] o_read_span,
    output logic [CW-1:0] o_write_span
);

    // captured word
    logic [2:0]    r_kind;
    logic [7:0]    r_wdata;
    logic [CW-1:0] r_dcount;
    logic [AW-1:0] r_poff;

    // ring state
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_held, n_held;
    logic [CW-1:0] r_cap;

    // result
    logic          r_ok, n_ok;
    logic [CW-1:0] r_done, n_done;
    logic          r_rd_sel, n_rd_sel;

    // byte store
    logic [7:0]    r_store [DEPTH];
    logic [7:0]    r_mem_q;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;

    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] drop_n;
    logic [CW:0]   head_sum;
    logic [CW:0]   ptr_wrap;
    logic [CW:0]   span_sum;
    logic [CW-1:0] free_bytes;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_wdata  <= i_write_data;
            r_dcount <= i_discard_count;
            r_poff   <= i_peek_offset;
        end
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_held   = r_held;
        n_ok     = 1'b0;
        n_done   = '0;
        n_rd_sel = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_head;
        ptr_inc  = '0;
        drop_n   = '0;
        head_sum = '0;
        ptr_wrap = '0;
        unique case (t_kind'(r_kind))
            KIND_WRITE: begin
                if (r_held < r_cap) begin
                    mem_we   = 1'b1;
                    mem_addr = r_tail;
                    ptr_inc  = {1'b0, r_tail} + CW'(1);
                    n_tail   = (ptr_inc >= r_cap) ? '0 : ptr_inc[AW-1:0];
                    n_held   = r_held + CW'(1);
                    n_ok     = 1'b1;
                end
            end
            KIND_READ: begin
                if (r_held != '0) begin
                    mem_re   = 1'b1;
                    mem_addr = r_head;
                    ptr_inc  = {1'b0, r_head} + CW'(1);
                    n_head   = (ptr_inc >= r_cap) ? '0 : ptr_inc[AW-1:0];
                    n_held   = r_held - CW'(1);
                    n_ok     = 1'b1;
                    n_rd_sel = 1'b1;
                    if (n_held == '0) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                end
            end
            KIND_DISCARD: begin
                drop_n   = (r_dcount > r_held) ? r_held : r_dcount;
                head_sum = {2'b00, r_head} + {1'b0, drop_n};
                ptr_wrap = (head_sum >= {1'b0, r_cap}) ? head_sum - {1'b0, r_cap}
                                                       : head_sum;
                n_head   = ptr_wrap[AW-1:0];
                n_held   = r_held - drop_n;
                n_done   = drop_n;
                n_ok     = 1'b1;
                if (n_held == '0) begin
                    n_head = '0;
                    n_tail = '0;
                end
            end
            KIND_PEEK: begin
                if ({1'b0, r_poff} < r_held) begin
                    head_sum = {2'b00, r_head} + {2'b00, r_poff};
                    ptr_wrap = (head_sum >= {1'b0, r_cap}) ? head_sum - {1'b0, r_cap}
                                                           : head_sum;
                    mem_re   = 1'b1;
                    mem_addr = ptr_wrap[AW-1:0];
                    n_ok     = 1'b1;
                    n_rd_sel = 1'b1;
                end
            end
            KIND_STATUS: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_held <= '0;
            r_cap  <= CW'(DEPTH);
        end else begin
            if (i_cmd.execute) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_held <= n_held;
            end
            // capacity only changes while the buffer is empty
            if (i_cfg_we && r_held == '0) begin
                if (i_cfg_capacity == '0) begin
                    r_cap <= CW'(1);
                end else if (i_cfg_capacity > CW'(DEPTH)) begin
                    r_cap <= CW'(DEPTH);
                end else begin
                    r_cap <= i_cfg_capacity;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_ok     <= n_ok;
            r_done   <= n_done;
            r_rd_sel <= n_rd_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && mem_we) begin
            r_store[mem_addr] <= r_wdata;
        end
        if (i_cmd.execute && mem_re) begin
            r_mem_q <= r_store[mem_addr];
        end
    end

    assign span_sum   = {2'b00, r_head} + {1'b0, r_held};
    assign free_bytes = r_cap - r_held;

    assign o_read_data  = r_rd_sel ? r_mem_q : '0;
    assign o_ok         = r_ok;
    assign o_done_count = r_done;
    assign o_fill_level = r_held;
    assign o_read_span  = (span_sum >= {1'b0, r_cap}) ? r_cap - {1'b0, r_head} : r_held;
    assign o_write_span = (({1'b0, r_tail} + free_bytes) >= r_cap) ? r_cap - {1'b0, r_tail}
                                                                    : free_bytes;

endmodule
